### rtl/rgb_ab_pkg.sv
`default_nettype none

package rgb_ab_pkg;

  localparam logic [4:0]  ALPHA_FULL  = 5'd31;
  localparam logic [11:0] RECIP31     = 12'd2115;
  localparam int          RECIP_SHIFT = 16;

  typedef enum logic [1:0] {
    MODE_MATTE = 2'd0,
    MODE_DEST  = 2'd1,
    MODE_MAX   = 2'd2,
    MODE_RAW   = 2'd3
  } mode_t;

  typedef enum logic {
    CFG_MODE  = 1'b0,
    CFG_MATTE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
  } rgb_t;

  typedef struct packed {
    logic [9:0]  r;
    logic [10:0] g;
    logic [9:0]  b;
  } prod_t;

  typedef struct packed {
    logic load_mul;
    logic load_div;
  } scale_ctl_t;

  typedef struct packed {
    logic  a_zero;
    logic  a_full;
    rgb_t  src;
    logic [15:0] dest;
  } side_t;

  // Exact floor(p / 31) for p up to 63 * 31.
  function automatic logic [5:0] div31(input logic [10:0] p);
    logic [22:0] m;
    m = 23'(p) * 23'(RECIP31);
    return m[RECIP_SHIFT+5:RECIP_SHIFT];
  endfunction

endpackage

`default_nettype wire

### rtl/rgb565_alpha_blend_core.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_ready    pos_x, pos_y, src_color, src_alpha, dest_pixel
// out_      result     out_valid / out_ready  x, y, write_enable, color
// cfg_      write      cfg_we                 cfg_index, cfg_data
//
// One request per cycle is accepted while in_ready is high; a stall at out_ready can hold it.
// The pipeline has four register stages: input decode, channel multiply,
// division by 31 through a reciprocal multiply, and the final mix in the output register.
// Reset clears the valid bits and the registers to mode 0 with a black matte.
// A stall holds each full stage with no empty stage after it; empty stages still fill, so bubbles are squeezed out.
module rgb565_alpha_blend_core #(
  parameter int COORD_WIDTH = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [COORD_WIDTH-1:0] in_pos_x,
  input  wire logic [COORD_WIDTH-1:0] in_pos_y,
  input  wire logic [15:0]            in_src_color,
  input  wire logic [7:0]             in_src_alpha,
  input  wire logic [15:0]            in_dest_pixel,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [COORD_WIDTH-1:0]      out_x,
  output logic [COORD_WIDTH-1:0]      out_y,
  output logic                        out_write_enable,
  output logic [15:0]                 out_color,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [15:0]            cfg_data
);
  import rgb_ab_pkg::*;

  mode_t       mode_r;
  logic [15:0] matte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MATTE;
      matte_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:  mode_r  <= mode_t'(cfg_data[1:0]);
        CFG_MATTE: matte_r <= cfg_data;
        default:   mode_r  <= mode_r;
      endcase
    end
  end

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // Stage 1: cut alpha to five bits and pick the second color to mix.
  logic [4:0]  alpha_nxt;
  logic [15:0] oth_nxt;

  assign alpha_nxt = in_src_alpha[7:3];

  always_comb begin
    case (mode_r)
      MODE_MATTE: oth_nxt = matte_r;
      MODE_DEST:  oth_nxt = in_dest_pixel;
      default:    oth_nxt = '0;
    endcase
  end

  logic [COORD_WIDTH-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  side_t      side1_r, side2_r, side3_r;
  rgb_t       src1_r, oth1_r;
  logic [4:0] wa1_r, wo1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      x1_r           <= in_pos_x;
      y1_r           <= in_pos_y;
      side1_r.a_zero <= (alpha_nxt == '0);
      side1_r.a_full <= (alpha_nxt == ALPHA_FULL);
      side1_r.src    <= rgb_t'(in_src_color);
      side1_r.dest   <= in_dest_pixel;
      src1_r         <= rgb_t'(in_src_color);
      oth1_r         <= rgb_t'(oth_nxt);
      wa1_r          <= alpha_nxt;
      wo1_r          <= ALPHA_FULL - alpha_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      side2_r <= side1_r;
    end
    if (en3) begin
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      side3_r <= side2_r;
    end
  end

  // Stages 2 and 3: multiply each channel by its weight, then divide by 31.
  scale_ctl_t sctl;
  rgb_t       src_sc, oth_sc;

  assign sctl.load_mul = en2;
  assign sctl.load_div = en3;

  rgb_ab_scale u_scale_src (
    .clk    (clk),
    .ctl    (sctl),
    .color  (src1_r),
    .weight (wa1_r),
    .scaled (src_sc)
  );

  rgb_ab_scale u_scale_oth (
    .clk    (clk),
    .ctl    (sctl),
    .color  (oth1_r),
    .weight (wo1_r),
    .scaled (oth_sc)
  );

  // Stage 4: add the two halves per channel and apply the mode, unless alpha is zero or full.
  rgb_t        sum;
  logic [15:0] color_nxt;
  logic        we_nxt;

  assign sum.r = src_sc.r + oth_sc.r;
  assign sum.g = src_sc.g + oth_sc.g;
  assign sum.b = src_sc.b + oth_sc.b;

  always_comb begin
    we_nxt = 1'b1;
    if (side3_r.a_zero) begin
      we_nxt    = 1'b0;
      color_nxt = '0;
    end else if (side3_r.a_full) begin
      color_nxt = side3_r.src;
    end else begin
      case (mode_r)
        MODE_MATTE, MODE_DEST: color_nxt = sum;
        MODE_MAX: begin
          color_nxt = (src_sc < side3_r.dest) ? side3_r.dest : src_sc;
        end
        default: color_nxt = src_sc;
      endcase
    end
  end

  logic [COORD_WIDTH-1:0] x4_r, y4_r;
  logic                   we4_r;
  logic [15:0]            color4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      x4_r     <= x3_r;
      y4_r     <= y3_r;
      we4_r    <= we_nxt;
      color4_r <= color_nxt;
    end
  end

  assign out_valid        = v4_r;
  assign out_x            = x4_r;
  assign out_y            = y4_r;
  assign out_write_enable = we4_r;
  assign out_color        = color4_r;

  a_transparent_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_color == '0)
    else $error("transparent result carries a color");

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ready)
    else $error("request refused with an empty first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && v4_r && !out_ready |-> !in_ready)
    else $error("request taken while the pipeline is full and stalled");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !v4_r |=> v4_r)
    else $error("result did not move into an empty output stage");

endmodule

`default_nettype wire

### rtl/rgb_ab_scale.sv
`default_nettype none

module rgb_ab_scale (
  input  wire logic                    clk,
  input  wire rgb_ab_pkg::scale_ctl_t  ctl,
  input  wire rgb_ab_pkg::rgb_t        color,
  input  wire logic [4:0]              weight,
  output rgb_ab_pkg::rgb_t             scaled
);
  import rgb_ab_pkg::*;

  prod_t prod_r;
  rgb_t  quot_r;

  always_ff @(posedge clk) begin
    if (ctl.load_mul) begin
      prod_r.r <= 10'(color.r) * 10'(weight);
      prod_r.g <= 11'(color.g) * 11'(weight);
      prod_r.b <= 10'(color.b) * 10'(weight);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_div) begin
      quot_r.r <= 5'(div31(11'(prod_r.r)));
      quot_r.g <= div31(prod_r.g);
      quot_r.b <= 5'(div31(11'(prod_r.b)));
    end
  end

  assign scaled = quot_r;

endmodule

`default_nettype wire
